// ===== rtl/pileup_consensus_base_caller_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pileup consensus base caller
// Shared property shorthands; each expects clk and rst in the calling scope.
// ----------------------------------------------------------------------------
`ifndef PILEUP_CONSENSUS_BASE_CALLER_TOP_DEFINES_SVH
`define PILEUP_CONSENSUS_BASE_CALLER_TOP_DEFINES_SVH

// Same-cycle implication, off while in reset.
`define PCBC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset.
`define PCBC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pcbc_pkg.sv =====
// ----------------------------------------------------------------------------
// pcbc_pkg
// Shared types, constants and the IUPAC lookup for the consensus base caller.
// ----------------------------------------------------------------------------
package pcbc_pkg;

  localparam int QUAL_W          = 24;
  localparam int DIV_BITS_STEP   = 2;
  localparam int DIV_STEPS       = QUAL_W / DIV_BITS_STEP;
  localparam int DIV_CNT_W       = $clog2(DIV_STEPS);
  localparam int ADJ_W           = 3;
  localparam int LOW_COVERAGE    = 5;

  typedef enum logic [1:0] {
    OP_ADD       = 2'd0,
    OP_CLEAR     = 2'd1,
    OP_CONSENSUS = 2'd2,
    OP_INSERTION = 2'd3
  } op_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic add;
    logic clear;
    logic scan_start;
    logic scan_step;
    logic eval;
    logic div_step;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic scan_last;
    logic need_div;
    logic div_last;
    logic out_free;
  } sts_t;

  localparam logic [6:0] CH_N = 7'h4E;
  localparam logic [6:0] CH_A = 7'h41;
  localparam logic [6:0] CH_C = 7'h43;
  localparam logic [6:0] CH_M = 7'h4D;
  localparam logic [6:0] CH_G = 7'h47;
  localparam logic [6:0] CH_R = 7'h52;
  localparam logic [6:0] CH_S = 7'h53;
  localparam logic [6:0] CH_V = 7'h56;
  localparam logic [6:0] CH_T = 7'h54;
  localparam logic [6:0] CH_W = 7'h57;
  localparam logic [6:0] CH_Y = 7'h59;
  localparam logic [6:0] CH_H = 7'h48;
  localparam logic [6:0] CH_K = 7'h4B;
  localparam logic [6:0] CH_D = 7'h44;
  localparam logic [6:0] CH_B = 7'h42;

  // Presence bits: bit 0 A, bit 1 C, bit 2 G, bit 3 T
  function automatic logic [6:0] iupac_letter(input logic [3:0] present);
    logic [6:0] letter;
    case (present)
      4'd1:    letter = CH_A;
      4'd2:    letter = CH_C;
      4'd3:    letter = CH_M;
      4'd4:    letter = CH_G;
      4'd5:    letter = CH_R;
      4'd6:    letter = CH_S;
      4'd7:    letter = CH_V;
      4'd8:    letter = CH_T;
      4'd9:    letter = CH_W;
      4'd10:   letter = CH_Y;
      4'd11:   letter = CH_H;
      4'd12:   letter = CH_K;
      4'd13:   letter = CH_D;
      4'd14:   letter = CH_B;
      default: letter = CH_N;
    endcase
    return letter;
  endfunction

endpackage

// ===== rtl/pileup_consensus_base_caller_top.sv =====
// ----------------------------------------------------------------------------
// pileup_consensus_base_caller_top
// Consensus base caller for one alignment column with quality and IUPAC code.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_axis    in         tuser: opcode; tdata: symbol, base_quality, depth_size
//  m_axis    out        tdata: best_symbol, call_quality, called, column_empty,
//                       iupac_code
//
//  Add and clear words give no result word. A query scans every symbol and
//  decides, then runs the two-bit-per-cycle divider when a base is called.
//  Reset (rst, synchronous) zeroes every count and quality sum at once.
//  A waiting result word holds the output register; adds and clears carry on,
//  and a following query stalls only at its final load.
// ----------------------------------------------------------------------------
module pileup_consensus_base_caller_top
  import pcbc_pkg::*;
#(
  parameter int NUM_SYMBOLS = 5,
  parameter int COUNT_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] symbol, [10:3] base_quality, [26:11] depth_size, [31:27] zero
  input  logic [31:0] s_axis_tdata,
  // [1:0] opcode
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] best_symbol, [26:3] call_quality, [27] called, [28] column_empty,
  // [35:29] iupac_code, [39:36] zero
  output logic [39:0] m_axis_tdata
);

  cmd_t        cmd;
  sts_t        sts;
  logic [2:0]  best_symbol;
  logic [23:0] call_quality;
  logic        called;
  logic        column_empty;
  logic [6:0]  iupac_code;

  // Sequence every word through the controller
  pcbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .opcode   (s_axis_tuser),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold the column, scan it, divide and register the result word
  pcbc_datapath #(
    .NUM_SYMBOLS (NUM_SYMBOLS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .opcode       (s_axis_tuser),
    .symbol       (s_axis_tdata[2:0]),
    .base_quality (s_axis_tdata[10:3]),
    .depth_size   (s_axis_tdata[26:11]),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .best_symbol  (best_symbol),
    .call_quality (call_quality),
    .called       (called),
    .column_empty (column_empty),
    .iupac_code   (iupac_code)
  );

  // Pack the result fields, lowest first, padded to whole bytes
  assign m_axis_tdata = {4'd0, iupac_code, column_empty, called, call_quality, best_symbol};

endmodule

// ===== rtl/pcbc_div.sv =====
// ----------------------------------------------------------------------------
// pcbc_div
// Iterative restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module pcbc_div
  import pcbc_pkg::*;
#(
  parameter int DW = 16
) (
  input  logic              clk,
  input  logic              load,
  input  logic              step,
  input  logic [QUAL_W-1:0] dividend,
  input  logic [DW-1:0]     divisor,
  output logic [QUAL_W-1:0] quotient,
  output logic              last
);

  logic [DW:0]          rem;
  logic [QUAL_W-1:0]    quo;
  logic [DW-1:0]        dvsr;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DW:0]          rem_next;
  logic [QUAL_W-1:0]    quo_next;

  always_comb begin
    rem_next = rem;
    quo_next = quo;
    for (int k = 0; k < DIV_BITS_STEP; k++) begin
      rem_next = {rem_next[DW-1:0], quo_next[QUAL_W-1]};
      quo_next = {quo_next[QUAL_W-2:0], 1'b0};
      if (rem_next >= {1'b0, dvsr}) begin
        rem_next    = rem_next - {1'b0, dvsr};
        quo_next[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem  <= '0;
      quo  <= dividend;
      dvsr <= divisor;
      cnt  <= '0;
    end else if (step) begin
      rem <= rem_next;
      quo <= quo_next;
      cnt <= cnt + 1'b1;
    end
  end

  assign last     = (cnt == DIV_CNT_W'(DIV_STEPS - 1));
  assign quotient = quo;

endmodule

// ===== rtl/pcbc_datapath.sv =====
// ----------------------------------------------------------------------------
// pcbc_datapath
// Column stores, symbol scan, call decision, divider and output register.
// ----------------------------------------------------------------------------
`include "pileup_consensus_base_caller_top_defines.svh"

module pcbc_datapath
  import pcbc_pkg::*;
#(
  parameter int NUM_SYMBOLS = 5,
  parameter int COUNT_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [1:0]  opcode,
  input  logic [2:0]  symbol,
  input  logic [7:0]  base_quality,
  input  logic [15:0] depth_size,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  best_symbol,
  output logic [23:0] call_quality,
  output logic        called,
  output logic        column_empty,
  output logic [6:0]  iupac_code
);

  localparam int IW = $clog2(NUM_SYMBOLS);
  localparam int CW = COUNT_BITS;
  localparam int TW = COUNT_BITS + $clog2(NUM_SYMBOLS);
  localparam int EW = (TW > 16) ? TW : 16;
  localparam int DW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  logic [CW-1:0]     counts [NUM_SYMBOLS];
  logic [QUAL_W-1:0] qsums  [NUM_SYMBOLS];

  logic [IW-1:0]     rd_addr;
  logic [CW-1:0]     rd_cnt;
  logic [QUAL_W-1:0] rd_q;
  logic              sym_ok;
  logic [CW-1:0]     cnt_inc;
  logic [QUAL_W:0]   q_sum;
  logic [QUAL_W-1:0] q_inc;

  logic [IW-1:0]     scan_idx;
  logic [IW-1:0]     best_idx;
  logic [CW-1:0]     best_cnt;
  logic [QUAL_W-1:0] best_q;
  logic [TW-1:0]     total;
  logic [3:0]        present;
  logic              op_ins;
  logic [15:0]       size;

  logic              need_div_r;
  logic [ADJ_W-1:0]  adj_r;

  // Evaluation terms
  logic [EW-1:0]     total_e;
  logic [EW-1:0]     size_e;
  logic [EW-1:0]     cnt_e;
  logic [EW-1:0]     noninsert;
  logic              low_size;
  logic              ev_need_div;
  logic [DW-1:0]     ev_divisor;
  logic [ADJ_W-1:0]  ev_adj;

  logic [QUAL_W-1:0] quotient;
  logic [QUAL_W-1:0] q_raw;
  logic [QUAL_W-1:0] q_final;

  // One read port: the add symbol during an add, the scan index otherwise
  assign rd_addr = cmd.add ? IW'(symbol) : scan_idx;
  assign rd_cnt  = counts[rd_addr];
  assign rd_q    = qsums[rd_addr];
  assign sym_ok  = (int'(symbol) < NUM_SYMBOLS);
  assign cnt_inc = (rd_cnt == '1) ? rd_cnt : rd_cnt + 1'b1;
  assign q_sum   = {1'b0, rd_q} + (QUAL_W + 1)'(base_quality);
  assign q_inc   = q_sum[QUAL_W] ? '1 : q_sum[QUAL_W-1:0];

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_SYMBOLS; i++) begin
      if (rst || cmd.clear) begin
        counts[i] <= '0;
        qsums[i]  <= '0;
      end else if (cmd.add && sym_ok && rd_addr == IW'(i)) begin
        counts[i] <= cnt_inc;
        qsums[i]  <= q_inc;
      end
    end
  end

  // Scan one symbol a cycle: best pick, exact total, A/C/G/T presence
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_idx <= '0;
      best_idx <= '0;
      best_cnt <= '0;
      best_q   <= '0;
      total    <= '0;
      present  <= '0;
      op_ins   <= (op_t'(opcode) == OP_INSERTION);
      size     <= depth_size;
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + 1'b1;
      total    <= total + TW'(rd_cnt);
      if (rd_cnt > best_cnt || (rd_cnt == best_cnt && rd_q > best_q)) begin
        best_idx <= scan_idx;
        best_cnt <= rd_cnt;
        best_q   <= rd_q;
      end
      for (int j = 0; j < 4; j++) begin
        if (j < NUM_SYMBOLS && int'(scan_idx) == j) begin
          present[j] <= (rd_cnt != '0);
        end
      end
    end
  end

  assign sts.scan_last = (scan_idx == IW'(NUM_SYMBOLS - 1));

  // Call decision from the scan results
  assign total_e   = EW'(total);
  assign size_e    = EW'(size);
  assign cnt_e     = EW'(best_cnt);
  assign noninsert = (total_e > size_e) ? '0 : size_e - total_e;
  assign low_size  = (size < 16'(LOW_COVERAGE));

  always_comb begin
    ev_need_div = 1'b0;
    ev_divisor  = DW'(best_cnt);
    ev_adj      = '0;
    if (!op_ins) begin
      ev_need_div = (total != '0);
      if (total < TW'(LOW_COVERAGE)) begin
        ev_adj = ADJ_W'(total - TW'(best_cnt));
      end
    end else begin
      ev_need_div = (total_e > noninsert) && (cnt_e > noninsert);
      if (low_size) begin
        if (cnt_e < size_e) begin
          ev_adj = ADJ_W'(size_e - cnt_e);
        end
      end else begin
        ev_divisor = DW'(size);
      end
    end
  end

  assign sts.need_div = ev_need_div;

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      need_div_r <= ev_need_div;
      adj_r      <= ev_adj;
    end
  end

  pcbc_div #(
    .DW (DW)
  ) u_div (
    .clk      (clk),
    .load     (cmd.eval),
    .step     (cmd.div_step),
    .dividend (best_q),
    .divisor  (ev_divisor),
    .quotient (quotient),
    .last     (sts.div_last)
  );

  // Reduce by disagreeing reads only where that leaves a positive quality
  assign q_raw   = need_div_r ? quotient : '0;
  assign q_final = (q_raw > QUAL_W'(adj_r)) ? q_raw - QUAL_W'(adj_r) : q_raw;

  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      best_symbol  <= need_div_r ? 3'(best_idx) : 3'd0;
      call_quality <= q_final;
      called       <= need_div_r;
      column_empty <= (total == '0);
      iupac_code   <= iupac_letter(present);
    end
  end

  `PCBC_ASSERT_NXT(a_clear_empties, cmd.clear, counts[0] == '0 && qsums[0] == '0, "clear left a count")
  `PCBC_ASSERT_IMP(a_load_when_free, cmd.load_out, sts.out_free, "result loaded over a waiting word")
  `PCBC_ASSERT_IMP(a_valid_from_load, $rose(out_valid), $past(cmd.load_out), "result valid without a load")

endmodule

// ===== rtl/pcbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// pcbc_ctrl
// Sequencer: accepts words, runs scan, decision, division and result load.
// ----------------------------------------------------------------------------
`include "pileup_consensus_base_caller_top_defines.svh"

module pcbc_ctrl
  import pcbc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] opcode,
  input  sts_t       sts,
  output cmd_t       cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_EVAL = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  // Take no word while in reset
  assign in_ready = (state == S_IDLE) && !rst;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op_t'(opcode))
            OP_ADD:   cmd.add   = 1'b1;
            OP_CLEAR: cmd.clear = 1'b1;
            default: begin
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = sts.need_div ? S_DIV : S_DONE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `PCBC_ASSERT_NXT(a_scan_to_eval, state == S_SCAN && sts.scan_last, state == S_EVAL, "scan did not end in evaluation")
  `PCBC_ASSERT_NXT(a_skip_div, state == S_EVAL && !sts.need_div, state == S_DONE, "division run without a call")

endmodule

// ===== dv/consensus_call_checker.sv =====
// ----------------------------------------------------------------------------
// consensus_call_checker
// Watches both stream channels of the consensus base caller, keeps its own
// copy of the column counts and quality sums, predicts each query's result
// word and compares every field of the words that come out.
// ----------------------------------------------------------------------------
module consensus_call_checker
  import pcbc_pkg::*;
#(
  parameter int NUM_SYMBOLS = 5,
  parameter int COUNT_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // [2:0] symbol, [10:3] base_quality, [26:11] depth_size, [31:27] zero
  input  logic [31:0] s_axis_tdata,
  // [1:0] opcode
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] best_symbol, [26:3] call_quality, [27] called, [28] column_empty,
  // [35:29] iupac_code, [39:36] zero
  input  logic [39:0] m_axis_tdata,
  output int          pending_calls,
  output int          failures
);

  typedef struct packed {
    logic [2:0]        best_symbol;
    logic [QUAL_W-1:0] call_quality;
    logic              called;
    logic              column_empty;
    logic [6:0]        iupac_code;
  } call_t;

  // Letter per presence pattern, pattern 0 in the lowest seven bits
  localparam logic [16*7-1:0] LETTERS = {CH_N, CH_B, CH_D, CH_K, CH_H, CH_Y, CH_W, CH_T,
                                         CH_V, CH_S, CH_R, CH_G, CH_M, CH_C, CH_A, CH_N};
  localparam logic [QUAL_W-1:0]     QSUM_MAX  = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [COUNT_BITS-1:0] read_counts [NUM_SYMBOLS];
  logic [QUAL_W-1:0]     qual_sums   [NUM_SYMBOLS];
  call_t                 expected_calls [$];

  initial begin
    pending_calls = 0;
    failures      = 0;
  end

  function automatic call_t predict_call(input op_t op, input logic [15:0] depth);
    call_t      call;
    longint     total;
    longint     noninsert;
    longint     c;
    longint     q;
    longint     size;
    longint     bc;
    longint     bq;
    int         best;
    logic [3:0] present;
    call    = '0;
    total   = 0;
    q       = 0;
    bc      = 0;
    bq      = 0;
    best    = 0;
    present = '0;
    size    = longint'(depth);
    for (int i = 0; i < NUM_SYMBOLS; i++) begin
      total += longint'(read_counts[i]);
      if (read_counts[i] > bc || (read_counts[i] == bc && qual_sums[i] > bq)) begin
        best = i;
        bc   = longint'(read_counts[i]);
        bq   = longint'(qual_sums[i]);
      end
    end
    for (int i = 0; i < 4 && i < NUM_SYMBOLS; i++) present[i] = (read_counts[i] != 0);
    c = longint'(read_counts[best]);
    if (op == OP_CONSENSUS) begin
      if (total != 0) begin
        q = qual_sums[best] / c;
        // thin coverage: take off one per disagreeing read
        if (total < LOW_COVERAGE && q > total - c) q -= total - c;
        call.best_symbol = best[2:0];
        call.called      = 1'b1;
      end
    end else begin
      noninsert = (total > size) ? 0 : size - total;
      if (total > noninsert && c > noninsert) begin
        if (size < LOW_COVERAGE) begin
          q = qual_sums[best] / c;
          if (c < size && q > size - c) q -= size - c;
        end else begin
          q = qual_sums[best] / size;
        end
        call.best_symbol = best[2:0];
        call.called      = 1'b1;
      end
    end
    call.call_quality = QUAL_W'(q);
    call.column_empty = (total == 0);
    call.iupac_code   = LETTERS[int'(present) * 7 +: 7];
    return call;
  endfunction

  task automatic report_mismatch(input string what, input logic [39:0] got,
                                 input logic [39:0] want);
    // print the first few, keep counting the rest
    if (failures < 32)
      $display("mismatch in %s: got 0x%0h, expected 0x%0h", what, got, want);
    failures++;
  endtask

  always @(posedge clk) begin : watch
    call_t             want;
    logic [2:0]        sym;
    logic [QUAL_W:0]   sum;
    if (rst) begin
      for (int i = 0; i < NUM_SYMBOLS; i++) begin
        read_counts[i] = '0;
        qual_sums[i]   = '0;
      end
    end else begin
      // check the result word leaving the block
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_calls.size() == 0) begin
          report_mismatch("unexpected result word", m_axis_tdata, '0);
        end else begin
          want = expected_calls.pop_front();
          if (m_axis_tdata[2:0] != want.best_symbol)
            report_mismatch("best_symbol", 40'(m_axis_tdata[2:0]), 40'(want.best_symbol));
          if (m_axis_tdata[26:3] != want.call_quality)
            report_mismatch("call_quality", 40'(m_axis_tdata[26:3]),
                            40'(want.call_quality));
          if (m_axis_tdata[27] != want.called)
            report_mismatch("called", 40'(m_axis_tdata[27]), 40'(want.called));
          if (m_axis_tdata[28] != want.column_empty)
            report_mismatch("column_empty", 40'(m_axis_tdata[28]), 40'(want.column_empty));
          if (m_axis_tdata[35:29] != want.iupac_code)
            report_mismatch("iupac_code", 40'(m_axis_tdata[35:29]), 40'(want.iupac_code));
        end
      end
      // advance the column state on the word entering the block
      if (s_axis_tvalid && s_axis_tready) begin
        sym = s_axis_tdata[2:0];
        case (op_t'(s_axis_tuser))
          OP_ADD: begin
            if (sym < NUM_SYMBOLS) begin
              if (read_counts[sym] != COUNT_MAX) read_counts[sym] = read_counts[sym] + 1'b1;
              sum = (QUAL_W + 1)'(qual_sums[sym]) + (QUAL_W + 1)'(s_axis_tdata[10:3]);
              qual_sums[sym] = (sum > QSUM_MAX) ? QSUM_MAX : sum[QUAL_W-1:0];
            end
          end
          OP_CLEAR: begin
            for (int i = 0; i < NUM_SYMBOLS; i++) begin
              read_counts[i] = '0;
              qual_sums[i]   = '0;
            end
          end
          default: expected_calls.push_back(predict_call(op_t'(s_axis_tuser),
                                                         s_axis_tdata[26:11]));
        endcase
      end
    end
    pending_calls <= expected_calls.size();
  end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the pileup consensus base caller: a directed
// opening, a back-to-back run and random column sequences, with bursty input,
// a stalling receiver and a separate checker that predicts every result word.
// ----------------------------------------------------------------------------
module tb;
  import pcbc_pkg::*;

  localparam int N_SYMBOLS    = 5;
  localparam int N_COUNT_BITS = 16;
  localparam int RANDOM_WORDS = 1270;
  localparam int HOLD_CYCLES  = 600;
  localparam int TAIL_CYCLES  = 40;
  localparam int CYCLE_LIMIT  = 1000000;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [2:0] symbol, [10:3] base_quality, [26:11] depth_size, [31:27] zero
  logic [31:0] s_axis_tdata  = '0;
  // [1:0] opcode
  logic [1:0]  s_axis_tuser  = OP_ADD;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [2:0] best_symbol, [26:3] call_quality, [27] called, [28] column_empty,
  // [35:29] iupac_code, [39:36] zero
  logic [39:0] m_axis_tdata;

  int pending_calls;
  int failures;
  int cycle_count   = 0;
  int counted_words = 0;   // words the block acts upon
  int col_reads     = 0;   // reads added since the last clear, for depth picks
  int burst_left    = 0;
  bit steady        = 1'b0; // send back to back, no gaps
  bit hold_request  = 1'b0; // ask the receiver for one long hold-off

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pileup_consensus_base_caller_top #(
    .NUM_SYMBOLS (N_SYMBOLS),
    .COUNT_BITS  (N_COUNT_BITS)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  consensus_call_checker #(
    .NUM_SYMBOLS (N_SYMBOLS),
    .COUNT_BITS  (N_COUNT_BITS)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pending_calls (pending_calls),
    .failures      (failures)
  );

  // Offer one word and hold it until the block takes it. Between bursts drop
  // tvalid for a random gap; within a burst the next word follows at once.
  task automatic send_word(input op_t op, input logic [2:0] sym, input logic [7:0] qual,
                           input logic [15:0] depth);
    int gap;
    if (burst_left <= 0 && !steady) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      burst_left = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 250)
                                                : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {5'd0, depth, qual, sym};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    // an add of an unknown symbol is dropped by the block
    if (!(op == OP_ADD && sym >= N_SYMBOLS)) counted_words++;
    if (op == OP_ADD && sym < N_SYMBOLS) col_reads++;
    if (op == OP_CLEAR) col_reads = 0;
  endtask

  // Stop offering and wait until every predicted word has come out.
  task automatic drain_calls();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_calls != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_depth();
    int d;
    case ($urandom_range(0, 5))
      0:       d = $urandom_range(0, 6);
      1:       d = 65535;
      2:       d = $urandom_range(0, 65535);
      default: d = col_reads + $urandom_range(0, 8) - 4;
    endcase
    if (d < 0) d = 0;
    if (d > 65535) d = 65535;
    return d[15:0];
  endfunction

  function automatic logic [7:0] pick_quality();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Receiver: segments of always ready, coin-flip ready and mostly stalled,
  // with one long hold-off on request while the sender keeps offering.
  initial begin : receiver
    int seg;
    int mode;
    forever begin
      mode = $urandom_range(0, 2);
      seg  = $urandom_range(20, 200);
      repeat (seg) begin
        @(posedge clk);
        if (hold_request) begin
          hold_request = 1'b0;
          m_axis_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int         base;
    int         n;
    int         nq;
    int         lead;
    bit         same_q;
    bit         hold_done;
    bit         pause_done;
    logic [7:0] fixed_q;
    logic [2:0] sym;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed opening: empty column, ignored symbols, ties, thin coverage
    send_word(OP_CONSENSUS, 3'd0, 8'd0, 16'd0);
    send_word(OP_INSERTION, 3'd0, 8'd0, 16'd0);
    send_word(OP_INSERTION, 3'd7, 8'd255, 16'hFFFF);
    send_word(OP_ADD, 3'd0, 8'd255, 16'd0);
    send_word(OP_ADD, 3'd7, 8'd0, 16'hFFFF);
    send_word(OP_ADD, 3'd5, 8'd255, 16'd0);
    send_word(OP_CONSENSUS, 3'd0, 8'd0, 16'd0);
    send_word(OP_ADD, 3'd1, 8'd0, 16'd0);
    send_word(OP_ADD, 3'd2, 8'd255, 16'd0);
    send_word(OP_ADD, 3'd3, 8'd128, 16'd0);
    send_word(OP_ADD, 3'd4, 8'd1, 16'd0);
    send_word(OP_CONSENSUS, 3'd0, 8'd0, 16'd0);   // counts all tied: A and G tie on quality, A wins on order
    send_word(OP_INSERTION, 3'd0, 8'd0, 16'd4);
    send_word(OP_INSERTION, 3'd0, 8'd0, 16'd5);
    send_word(OP_INSERTION, 3'd0, 8'd0, 16'hFFFF); // no call
    send_word(OP_ADD, 3'd4, 8'd200, 16'd0);
    send_word(OP_CONSENSUS, 3'd0, 8'd0, 16'd0);
    send_word(OP_CLEAR, 3'd0, 8'd0, 16'd0);
    send_word(OP_ADD, 3'd3, 8'd10, 16'd0);
    send_word(OP_ADD, 3'd3, 8'd20, 16'd0);
    send_word(OP_CONSENSUS, 3'd0, 8'd0, 16'd0);
    send_word(OP_ADD, 3'd1, 8'd3, 16'd0);
    send_word(OP_CONSENSUS, 3'd0, 8'd0, 16'd0);
    send_word(OP_INSERTION, 3'd0, 8'd0, 16'd3);
    send_word(OP_CLEAR, 3'd0, 8'd0, 16'd0);

    // Back-to-back reads on one symbol, then a few on another
    steady = 1'b1;
    repeat (40) send_word(OP_ADD, 3'd0, 8'd255, 16'd0);
    repeat (3) send_word(OP_ADD, 3'd1, 8'd1, 16'd0);
    steady = 1'b0;
    send_word(OP_CONSENSUS, 3'd0, 8'd0, 16'd0);
    send_word(OP_INSERTION, 3'd0, 8'd0, 16'hFFFF);
    send_word(OP_INSERTION, 3'd0, 8'd0, 16'd44);
    send_word(OP_INSERTION, 3'd0, 8'd0, 16'd0);
    send_word(OP_CLEAR, 3'd0, 8'd0, 16'd0);

    // Random part: mostly column sequences (clear, reads, queries), some noise
    base       = counted_words;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    while (counted_words - base < RANDOM_WORDS) begin
      if (!hold_done && counted_words - base >= 400) begin
        // long receiver hold-off: queries back up until the input stalls
        hold_done    = 1'b1;
        hold_request = 1'b1;
        repeat (16) begin
          send_word(OP_ADD, 3'($urandom_range(0, 4)), pick_quality(), 16'd0);
          send_word(OP_CONSENSUS, 3'd0, 8'd0, 16'd0);
          send_word(OP_INSERTION, 3'd0, 8'd0, pick_depth());
        end
      end
      if (!pause_done && counted_words - base >= 800) begin
        pause_done = 1'b1;
        drain_calls();
      end
      if ($urandom_range(0, 99) < 12) begin
        send_word(op_t'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                  8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
      end else begin
        if ($urandom_range(0, 2) != 0)
          send_word(OP_CLEAR, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                    16'($urandom_range(0, 65535)));
        n       = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        lead    = $urandom_range(0, 4);
        same_q  = 1'($urandom_range(0, 1));
        fixed_q = pick_quality();
        repeat (n) begin
          if ($urandom_range(0, 19) == 0) sym = 3'($urandom_range(5, 7));
          else if ($urandom_range(0, 2) == 0) sym = 3'(lead);
          else sym = 3'($urandom_range(0, 4));
          send_word(OP_ADD, sym, same_q ? fixed_q : pick_quality(),
                    16'($urandom_range(0, 65535)));
        end
        nq = $urandom_range(1, 3);
        repeat (nq)
          send_word($urandom_range(0, 1) ? OP_CONSENSUS : OP_INSERTION,
                    3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), pick_depth());
      end
    end

    // Drain, let the pipeline settle, then give the verdict
    drain_calls();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== pileup_consensus_base_caller_top.f =====
+incdir+rtl
rtl/pcbc_pkg.sv
rtl/pcbc_div.sv
rtl/pcbc_datapath.sv
rtl/pcbc_ctrl.sv
rtl/pileup_consensus_base_caller_top.sv
dv/consensus_call_checker.sv
dv/tb.sv
